@@ hdl/rar_pkg.sv @@
// Package for the rational arithmetic reducer: opcodes, field widths and the
// command and status groups between the controller and the datapath.
// No dependencies.
package rar_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned NUM_W  = 33;
  localparam int unsigned MAG_W  = 32;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul0;
    logic mul1;
    logic mul2;
    logic sum;
    logic norm;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_eq;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/rational_arith_reduce.sv @@
// Top level of the rational arithmetic reducer.
// Instantiates rar_ctrl and rar_dp; depends on rar_pkg.
//
// The block combines two signed 16-bit fractions by multiply, add, subtract
// or divide, moves the sign so that the denominator is positive and reduces
// the result by the greatest common divisor of numerator and denominator.
// Each input beat yields exactly one output beat carrying both the raw and
// the reduced fraction. A zero denominator raises the status flag and the
// reduced form then repeats the raw form; a zero numerator reduces to 0/1.
// One item at a time is worked on. An item passes through the accepting
// cycle, three multiplier passes, the sum, sign normalisation, the
// zero check and the hand-over to the output register. A nonzero fraction
// adds the binary gcd (one shift or subtract-and-shift each cycle, with
// the number of steps depending on the operand bits, until the two
// operands meet) and restoring division by the gcd; a zero numerator or
// denominator skips the gcd and division. The hand-over cycle is held for
// as long as the previous result has not been taken. A finished result
// waits in the output register while the next beat is taken in.
module rational_arith_reduce
  import rar_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [1:0] opcode, [17:2] a_num, [33:18] a_den, [49:34] b_num, [65:50] b_den
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] raw_num, [62:32] raw_den, [94:63] red_num, [125:95] red_den
  output logic [127:0] m_tdata,
  // [0] status
  output logic         m_tuser
);

  cmd_t cmd;
  sts_t sts;

  rar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rar_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

@@ hdl/rar_ctrl.sv @@
// Controller of the rational arithmetic reducer: a one-hot sequencer that
// steps the datapath through multiply, normalise, gcd and division phases.
// Depends on rar_pkg.
module rar_ctrl
  import rar_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL0   = 10'b00_0000_0010,
    S_MUL1   = 10'b00_0000_0100,
    S_MUL2   = 10'b00_0000_1000,
    S_SUM    = 10'b00_0001_0000,
    S_NORM   = 10'b00_0010_0000,
    S_CHECK  = 10'b00_0100_0000,
    S_GCD    = 10'b00_1000_0000,
    S_DIV    = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.norm   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.gcd_init = 1'b1;
        if (sts.den_zero || sts.num_zero) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_eq) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == {CNT_W{1'b1}}) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ hdl/rar_dp.sv @@
// Datapath of the rational arithmetic reducer: one shared multiplier, the
// binary gcd unit, two restoring dividers and the output register.
// Depends on rar_pkg.
module rar_dp
  import rar_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [71:0]  s_tdata,
  output logic [127:0] m_tdata,
  output logic         m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  cmd_t         cmd,
  output sts_t         sts
);

  opcode_t                 op;
  logic signed [IN_W-1:0]  an, ad, bn, bd;
  logic signed [PROD_W-1:0] t0, t1, den;
  logic signed [NUM_W-1:0] num;
  logic [MAG_W-1:0]        u, v, g, qn, qd;
  logic [CNT_W-1:0]        k;
  logic [MAG_W:0]          rn, rd;
  logic                    neg;

  logic signed [IN_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  num_sum;
  logic [MAG_W:0]           trial_n, trial_d, g_ext;

  logic [31:0] o_raw_num, o_red_num;
  logic [30:0] o_raw_den, o_red_den;
  logic        o_status;

  // Shared 16x16 multiplier, operands picked by the step in progress.
  always_comb begin
    mul_a = an;
    mul_b = bd;
    if (cmd.mul0) begin
      mul_a = an;
      mul_b = (op == OP_MUL) ? bn : bd;
    end else if (cmd.mul1) begin
      mul_a = bn;
      mul_b = ad;
    end else begin
      mul_a = ad;
      mul_b = (op == OP_DIV) ? bn : bd;
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    unique case (op)
      OP_ADD:  num_sum = NUM_W'(t0) + NUM_W'(t1);
      OP_SUB:  num_sum = NUM_W'(t0) - NUM_W'(t1);
      default: num_sum = NUM_W'(t0);
    endcase
  end

  assign g_ext   = {1'b0, g};
  assign trial_n = {rn[MAG_W-1:0], qn[MAG_W-1]};
  assign trial_d = {rd[MAG_W-1:0], qd[MAG_W-1]};

  assign sts.den_zero = (den == '0);
  assign sts.num_zero = (num == '0);
  assign sts.gcd_eq   = (u == v);
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode_t'(s_tdata[1:0]);
      an <= s_tdata[17:2];
      ad <= s_tdata[33:18];
      bn <= s_tdata[49:34];
      bd <= s_tdata[65:50];
    end
    if (cmd.mul0) t0 <= prod;
    if (cmd.mul1) t1 <= prod;
    if (cmd.mul2) den <= prod;
    if (cmd.sum) num <= num_sum;
    if (cmd.norm && den[PROD_W-1]) begin
      num <= -num;
      den <= -den;
    end
    if (cmd.gcd_init) begin
      neg <= num[NUM_W-1];
      u   <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      v   <= MAG_W'(den);
      k   <= '0;
    end
    // Binary gcd: strip common factors of two, then subtract and halve.
    if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end
    if (cmd.div_init) begin
      g  <= u << k;
      rn <= '0;
      rd <= '0;
      qn <= u_mag_reload();
      qd <= MAG_W'(den);
    end
    if (cmd.div_step) begin
      if (trial_n >= g_ext) begin
        rn <= trial_n - g_ext;
        qn <= {qn[MAG_W-2:0], 1'b1};
      end else begin
        rn <= trial_n;
        qn <= {qn[MAG_W-2:0], 1'b0};
      end
      if (trial_d >= g_ext) begin
        rd <= trial_d - g_ext;
        qd <= {qd[MAG_W-2:0], 1'b1};
      end else begin
        rd <= trial_d;
        qd <= {qd[MAG_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      o_raw_num <= num[31:0];
      o_raw_den <= den[30:0];
      if (den == '0) begin
        o_red_num <= num[31:0];
        o_red_den <= den[30:0];
        o_status  <= 1'b1;
      end else if (num == '0) begin
        o_red_num <= '0;
        o_red_den <= 31'd1;
        o_status  <= 1'b0;
      end else begin
        o_red_num <= neg ? -qn : qn;
        o_red_den <= qd[30:0];
        o_status  <= 1'b0;
      end
    end
  end

  // Magnitude of the normalised numerator, the dividend of the first divider.
  function automatic logic [MAG_W-1:0] u_mag_reload();
    u_mag_reload = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, o_red_den, o_red_num, o_raw_den, o_raw_num};
  assign m_tuser = o_status;

endmodule
